/* rtl/jcsw_pkg.sv */
// jcsw_pkg: shared types and constants for the joint current safety watchdog
// request and response beat layouts, register indexes, fixed-point widths
// no dependencies
package jcsw_pkg;

	localparam int JOINTS = 3;

	// register map of the configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DAMPING_GAIN  = 3'd0,
		REG_KNEE_GAIN     = 3'd1,
		REG_CURRENT_LIMIT = 3'd2,
		REG_SPEED_LIMIT   = 3'd3,
		REG_TIMEOUT_MS    = 3'd4
	} cfg_reg_t;

	// item kinds
	localparam logic MODE_COMMAND = 1'b0;
	localparam logic MODE_TICK    = 1'b1;

	// reset values of the registers
	localparam logic [15:0] DAMPING_GAIN_RST  = 16'd6554;
	localparam logic [15:0] KNEE_GAIN_RST     = 16'd10486;
	localparam logic [14:0] CURRENT_LIMIT_RST = 15'd4096;
	localparam logic [14:0] SPEED_LIMIT_RST   = 15'd5120;
	localparam logic [15:0] TIMEOUT_MS_RST    = 16'd100;

	// Q.24 to Q4.12 rounding
	localparam int FRAC_SHIFT = 12;
	localparam int ROUND_HALF = 2048;

	typedef struct packed {
		logic               mode;
		logic signed [15:0] hip_ff;
		logic signed [15:0] thigh_ff;
		logic signed [15:0] knee_ff;
		logic signed [15:0] hip_speed;
		logic signed [15:0] thigh_speed;
		logic signed [15:0] knee_speed;
		logic        [31:0] now_ms;
	} req_t;

	typedef struct packed {
		logic signed [15:0] hip_drive;
		logic signed [15:0] thigh_drive;
		logic signed [15:0] knee_drive;
		logic               timed_out;
	} rsp_t;

endpackage

/* rtl/joint_current_safety_watchdog_top.sv */
// joint_current_safety_watchdog_top: three-joint current command with command watchdog
// input register, one pass of multiply/round/clip per joint, output register
// depends on jcsw_pkg
// a tick beat passes through the input register and then the output register to rsp
// one beat per cycle while req_stall is low; command beats update state and give no response
// the input stage only stalls while a tick waits behind a stalled response
// reset (arst_n low, asynchronous): registers to their defaults, stored
// feedforwards and last command time to zero, both stages empty
module joint_current_safety_watchdog_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [jcsw_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [jcsw_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                   req_valid,
	output logic                                   req_stall,
	input  jcsw_pkg::req_t                         req_data,
	output logic                                   rsp_valid,
	input  logic                                   rsp_stall,
	output jcsw_pkg::rsp_t                         rsp_data
);
	import jcsw_pkg::*;

	// configuration registers
	logic [15:0] damping_gain_q;
	logic [15:0] knee_gain_q;
	logic [14:0] current_limit_q;
	logic [14:0] speed_limit_q;
	logic [15:0] timeout_ms_q;

	// watchdog state
	logic               [31:0] last_cmd_q;
	logic signed [JOINTS-1:0][15:0] ff_q;

	// input stage
	logic valid_s1;
	req_t data_s1;
	logic advance;

	// output stage
	logic rsp_valid_q;
	rsp_t rsp_data_q;

	// per-joint datapath, one signed element per joint
	logic signed [JOINTS-1:0][15:0] ff_in;
	logic signed [15:0] spd       [JOINTS];
	logic signed [15:0] drive     [JOINTS];
	logic signed [16:0] gain      [JOINTS];
	logic signed [16:0] spd_x     [JOINTS];
	logic signed [16:0] over      [JOINTS];
	logic signed [33:0] prod_damp [JOINTS];
	logic signed [33:0] prod_over [JOINTS];
	logic signed [35:0] rnd_damp  [JOINTS];
	logic signed [35:0] rnd_over  [JOINTS];
	logic signed [35:0] sum_ff    [JOINTS];
	logic signed [16:0] speed_lim;
	logic signed [35:0] cur_lim;
	logic        [31:0] elapsed;
	logic               stale;
	rsp_t               rsp_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			damping_gain_q  <= DAMPING_GAIN_RST;
			knee_gain_q     <= KNEE_GAIN_RST;
			current_limit_q <= CURRENT_LIMIT_RST;
			speed_limit_q   <= SPEED_LIMIT_RST;
			timeout_ms_q    <= TIMEOUT_MS_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_DAMPING_GAIN:  damping_gain_q  <= cfg_data;
				REG_KNEE_GAIN:     knee_gain_q     <= cfg_data;
				REG_CURRENT_LIMIT: current_limit_q <= cfg_data[14:0];
				REG_SPEED_LIMIT:   speed_limit_q   <= cfg_data[14:0];
				REG_TIMEOUT_MS:    timeout_ms_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// a command beat always leaves s1; a tick needs room in the output register
	assign advance   = !valid_s1 || (data_s1.mode == MODE_COMMAND) || !rsp_valid_q || !rsp_stall;
	assign req_stall = !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && req_valid) begin
			data_s1 <= req_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_cmd_q <= '0;
			ff_q       <= '0;
		end else if (valid_s1 && data_s1.mode == MODE_COMMAND) begin
			last_cmd_q <= data_s1.now_ms;
			ff_q       <= ff_in;
		end
	end

	assign ff_in[0] = data_s1.hip_ff;
	assign ff_in[1] = data_s1.thigh_ff;
	assign ff_in[2] = data_s1.knee_ff;
	assign spd[0]   = data_s1.hip_speed;
	assign spd[1]   = data_s1.thigh_speed;
	assign spd[2]   = data_s1.knee_speed;

	// wrapping difference against the last command
	assign elapsed   = data_s1.now_ms - last_cmd_q;
	assign stale     = elapsed > {16'd0, timeout_ms_q};
	assign speed_lim = $signed({2'b00, speed_limit_q});
	assign cur_lim   = $signed({21'd0, current_limit_q});

	always_comb begin
		for (int j = 0; j < JOINTS; j++) begin
			gain[j]  = (j == JOINTS - 1) ? $signed({1'b0, knee_gain_q})
			                             : $signed({1'b0, damping_gain_q});
			spd_x[j] = $signed({spd[j][15], spd[j]});
			if (spd_x[j] > speed_lim) begin
				over[j] = spd_x[j] - speed_lim;
			end else if (spd_x[j] < -speed_lim) begin
				over[j] = spd_x[j] + speed_lim;
			end else begin
				over[j] = '0;
			end
			prod_damp[j] = $signed({1'b0, damping_gain_q}) * spd_x[j];
			prod_over[j] = gain[j] * over[j];
			// negate, add half an lsb, floor shift
			rnd_damp[j]  = (-36'(prod_damp[j]) + 36'sd2048) >>> FRAC_SHIFT;
			rnd_over[j]  = (-36'(prod_over[j]) + 36'sd2048) >>> FRAC_SHIFT;
			sum_ff[j]    = 36'($signed(ff_q[j])) + rnd_over[j];
			if (stale) begin
				if (rnd_damp[j] > cur_lim) begin
					drive[j] = 16'(cur_lim);
				end else if (rnd_damp[j] < -cur_lim) begin
					drive[j] = 16'(-cur_lim);
				end else begin
					drive[j] = 16'(rnd_damp[j]);
				end
			end else begin
				if (sum_ff[j] > 36'sd32767) begin
					drive[j] = 16'sh7fff;
				end else if (sum_ff[j] < -36'sd32768) begin
					drive[j] = 16'sh8000;
				end else begin
					drive[j] = 16'(sum_ff[j]);
				end
			end
		end
	end

	always_comb begin
		rsp_next.hip_drive   = drive[0];
		rsp_next.thigh_drive = drive[1];
		rsp_next.knee_drive  = drive[2];
		rsp_next.timed_out   = stale;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (valid_s1 && data_s1.mode == MODE_TICK && advance) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && data_s1.mode == MODE_TICK && advance) begin
			rsp_data_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

	// a tick leaving s1 always lands in the output register
	a_tick_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && data_s1.mode == MODE_TICK && advance) |=> rsp_valid_q)
		else $error("tick beat lost between stages");

	// a command beat records its arrival time
	a_cmd_time: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && data_s1.mode == MODE_COMMAND) |=> (last_cmd_q == $past(data_s1.now_ms)))
		else $error("last command time not updated");

	// the input side only waits behind a held tick
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (valid_s1 && data_s1.mode == MODE_TICK && rsp_valid_q))
		else $error("input stalled without a blocked tick");

	// a command beat never produces a response
	a_cmd_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && data_s1.mode == MODE_COMMAND && !rsp_valid_q) |=> !rsp_valid_q)
		else $error("response raised by a command beat");

endmodule
